// ----- rtl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and helper functions for the wheel odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [31:0] DPT_RESET   = 32'd2248839;
  localparam logic [30:0] TRACK_RESET = 31'd7864;
  localparam logic [31:0] INV_GAIN    = 32'h9B74_EDA8;
  localparam logic [31:0] BAM_PER_RAD = 32'd683565276;

  // Serial multiplier step counts: narrow operands fit in 34 bits.
  localparam int MUL_STEPS_NARROW = 34;
  localparam int MUL_STEPS_WIDE   = 64;
  // Divider: 64 dividend bits plus appended zero bits.
  localparam int DIV_NUM_BITS     = 64;
  localparam int DIV_ZEROS_WIDE   = 32;

  localparam logic REG_DIST_PER_TICK = 1'b0;
  localparam logic REG_TRACK_WIDTH   = 1'b1;

  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_OVERRIDE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MSUM,
    ST_MGAIN,
    ST_CORDIC,
    ST_MDIFF,
    ST_DHEAD,
    ST_MBAM,
    ST_MVS,
    ST_MVD,
    ST_DANG,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic start;
    logic wide;
  } mul_req_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Apply a sign to a magnitude and clamp to the signed 32-bit range.
  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic [33:0] v);
    logic [34:0] s;
    logic [31:0] r;
    s = {{3{acc[31]}}, acc} + {v[33], v};
    if (!s[34] && (s[33:31] != 3'b000)) begin
      r = 32'h7FFF_FFFF;
    end else if (s[34] && (s[33:31] != 3'b111)) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ddo_mul.sv -----
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  input  logic [63:0] a,
  input  logic [31:0] d,
  output logic        done,
  output logic [95:0] prod
);

  logic        busy;
  logic [6:0]  cnt;
  logic [31:0] hi;
  logic [63:0] lo;
  logic [31:0] dreg;
  logic        wide_r;
  logic [32:0] sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, dreg} : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.wide ? 7'(MUL_STEPS_WIDE - 1) : 7'(MUL_STEPS_NARROW - 1);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi     <= '0;
      lo     <= a;
      dreg   <= d;
      wide_r <= req.wide;
    end else if (busy) begin
      hi <= sum[32:1];
      lo <= {sum[0], lo[63:1]};
    end
  end

  // A narrow run leaves its low product bits in the top of lo.
  assign prod = wide_r ? {hi, lo} : {30'd0, hi, lo[63:30]};

endmodule

// ----- rtl/ddo_div.sv -----
// ----------------------------------------------------------------------------
// ddo_div
// Restoring divider, one quotient bit per cycle, with overflow sticky bit.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  input  logic [63:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [63:0] quot,
  output logic        ovf
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] numr;
  logic [31:0] rem;
  logic [30:0] den_r;
  logic [31:0] shifted;
  logic [32:0] trial;
  logic        qb;

  assign shifted = {rem[30:0], numr[63]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign qb      = !trial[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.wide ? 7'(DIV_NUM_BITS + DIV_ZEROS_WIDE - 1)
                         : 7'(DIV_NUM_BITS + FRAC_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      numr  <= num;
      rem   <= '0;
      quot  <= '0;
      ovf   <= 1'b0;
      den_r <= den;
    end else if (busy) begin
      numr <= {numr[62:0], 1'b0};
      rem  <= qb ? trial[31:0] : shifted;
      quot <= {quot[62:0], qb};
      ovf  <= ovf | quot[63];
    end
  end

endmodule

// ----- rtl/ddo_cordic.sv -----
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative CORDIC rotation, one micro-rotation per cycle, with quarter-turn
// pre-reduction and post-rotation.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] x0,
  input  logic [31:0] heading,
  output logic        done,
  output logic [33:0] xo,
  output logic [33:0] yo
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  logic                busy;
  logic [IW-1:0]       i;
  logic signed [33:0]  x, y, z;
  logic [1:0]          k;
  logic [31:0]         hsum;
  logic [31:0]         rr;
  logic signed [33:0]  xs, ys, at;

  assign hsum = heading + 32'h2000_0000;
  assign rr   = heading - {hsum[31:30], 30'd0};
  assign xs   = x >>> i;
  assign ys   = y >>> i;
  assign at   = {2'b00, atan_bam(5'(i))};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + IW'(1);
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x0;
      y <= '0;
      z <= {{2{rr[31]}}, rr};
      k <= hsum[31:30];
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  always_comb begin
    case (k)
      2'd1: begin
        xo = -y;
        yo = x;
      end
      2'd2: begin
        xo = -x;
        yo = -y;
      end
      2'd3: begin
        xo = y;
        yo = -x;
      end
      default: begin
        xo = x;
        yo = y;
      end
    endcase
  end

endmodule

// ----- rtl/diff_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: pose and velocity from encoder counts.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ stream. tuser selects an encoder sample or a
// pose override; tdata carries counts, rates and override pose. Each input
// word yields exactly one result word on the m_ stream carrying the pose
// after the word plus linear and angular velocity.
// An override word goes straight to the output state and is loaded into the
// output register once that register is free. An encoder sample runs five
// 34-step serial multiplies, one 64-step multiply, a CORDIC rotation of
// CORDIC_STEPS micro-rotations and two restoring divides of 96 and
// 64+FRAC_BITS steps, all run one after another by the sequencer. One word
// is in flight at a time: the next word is not taken until the result of
// the last has been loaded into the output register. Reset clears the pose,
// the previous counts and the output valid, and loads the register defaults.
// The result waits in an output register while m_tready is low; the next
// input word is taken meanwhile and held at its last step until the output
// register frees up. Registers are written through cfg_we/cfg_index/cfg_data
// while idle; this binds the user, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // left_count, right_count, left_rate, right_rate, est_x, est_y, est_heading
  input  logic [191:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pose_x, pose_y, pose_heading, lin_vel, ang_vel
  output logic [159:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SH_MEAN = 33 - FRAC_BITS;
  localparam int SH_DIFF = 32 - FRAC_BITS;

  st_t state, state_next;

  logic [31:0] dist_per_tick;
  logic [30:0] track_width;
  logic [31:0] prev_left, prev_right;
  logic [31:0] acc_x, acc_y, acc_heading;
  logic [32:0] sum_mag, diff_mag;
  logic        sum_neg, diff_neg;
  logic [16:0] vs_mag, vd_mag;
  logic        vs_neg, vd_neg;
  logic [31:0] lin, ang;

  // Unit handshakes.
  mul_req_t    mreq;
  logic [63:0] mul_a;
  logic [31:0] mul_d;
  logic        mul_done;
  logic [95:0] mul_prod;
  div_req_t    dreq;
  logic [63:0] div_num;
  logic        div_done;
  logic [63:0] div_quot;
  logic        div_ovf;
  logic        cor_start;
  logic [33:0] cor_x0;
  logic        cor_done;
  logic [33:0] cor_x, cor_y;

  // Combinational helpers.
  logic        accept;
  logic [31:0] dl, dr;
  logic [32:0] s33, d33;
  logic [16:0] vs17, vd17;
  logic [95:0] prod_mean, prod_diff;
  logic [31:0] m_clamp;
  logic [31:0] delta;
  logic [30:0] eff_track;
  logic        out_load;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign dl        = s_tdata[31:0]  - prev_left;
  assign dr        = s_tdata[63:32] - prev_right;
  assign s33       = {dl[31], dl} + {dr[31], dr};
  assign d33       = {dl[31], dl} - {dr[31], dr};
  assign vs17      = {s_tdata[79], s_tdata[79:64]} + {s_tdata[95], s_tdata[95:80]};
  assign vd17      = {s_tdata[79], s_tdata[79:64]} - {s_tdata[95], s_tdata[95:80]};
  assign prod_mean = mul_prod >> SH_MEAN;
  assign prod_diff = mul_prod >> SH_DIFF;
  // A mean travel above one half of the range is clamped before rotation.
  assign m_clamp   = (prod_mean > 96'h8000_0000) ? 32'h8000_0000 : prod_mean[31:0];
  assign delta     = diff_neg ? (32'd0 - mul_prod[63:32]) : mul_prod[63:32];
  assign eff_track = (track_width == 31'd0) ? 31'd1 : track_width;
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mreq       = '0;
    mul_a      = '0;
    mul_d      = dist_per_tick;
    dreq       = '0;
    div_num    = prod_diff[63:0];
    cor_start  = 1'b0;
    cor_x0     = sum_neg ? (34'd0 - {2'b00, mul_prod[63:32]}) : {2'b00, mul_prod[63:32]};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == KIND_OVERRIDE) ? ST_OUT : ST_PREP;
        end
      end
      ST_PREP: begin
        mreq.start = 1'b1;
        mul_a      = {31'd0, sum_mag};
        state_next = ST_MSUM;
      end
      ST_MSUM: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mul_a      = {32'd0, m_clamp};
          mul_d      = INV_GAIN;
          state_next = ST_MGAIN;
        end
      end
      ST_MGAIN: begin
        if (mul_done) begin
          cor_start  = 1'b1;
          state_next = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cor_done) begin
          mreq.start = 1'b1;
          mul_a      = {31'd0, diff_mag};
          state_next = ST_MDIFF;
        end
      end
      ST_MDIFF: begin
        if (mul_done) begin
          dreq.start = 1'b1;
          dreq.wide  = 1'b1;
          state_next = ST_DHEAD;
        end
      end
      ST_DHEAD: begin
        if (div_done) begin
          // Integer and fraction of the radians, scaled to a binary angle.
          mreq.start = 1'b1;
          mreq.wide  = 1'b1;
          mul_a      = div_quot;
          mul_d      = BAM_PER_RAD;
          state_next = ST_MBAM;
        end
      end
      ST_MBAM: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mul_a      = {47'd0, vs_mag};
          state_next = ST_MVS;
        end
      end
      ST_MVS: begin
        if (mul_done) begin
          mreq.start = 1'b1;
          mul_a      = {47'd0, vd_mag};
          state_next = ST_MVD;
        end
      end
      ST_MVD: begin
        if (mul_done) begin
          dreq.start = 1'b1;
          state_next = ST_DANG;
        end
      end
      ST_DANG: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_tick <= DPT_RESET;
      track_width   <= TRACK_RESET;
      prev_left     <= '0;
      prev_right    <= '0;
      acc_x         <= '0;
      acc_y         <= '0;
      acc_heading   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIST_PER_TICK: dist_per_tick <= cfg_data;
          REG_TRACK_WIDTH:   track_width   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (s_tuser == KIND_OVERRIDE) begin
          acc_x       <= s_tdata[127:96];
          acc_y       <= s_tdata[159:128];
          acc_heading <= s_tdata[191:160];
        end else begin
          prev_left  <= s_tdata[31:0];
          prev_right <= s_tdata[63:32];
        end
      end
      if (state == ST_CORDIC && cor_done) begin
        acc_x <= sat_add(acc_x, cor_x);
        acc_y <= sat_add(acc_y, cor_y);
      end
      if (state == ST_MBAM && mul_done) begin
        acc_heading <= acc_heading + delta;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_neg  <= s33[32];
      sum_mag  <= s33[32] ? (33'd0 - s33) : s33;
      diff_neg <= d33[32];
      diff_mag <= d33[32] ? (33'd0 - d33) : d33;
      vs_neg   <= vs17[16];
      vs_mag   <= vs17[16] ? (17'd0 - vs17) : vs17;
      vd_neg   <= vd17[16];
      vd_mag   <= vd17[16] ? (17'd0 - vd17) : vd17;
      lin      <= '0;
      ang      <= '0;
    end
    if (state == ST_MVS && mul_done) begin
      lin <= sat_mag(prod_mean[63:0], vs_neg);
    end
    if (state == ST_DANG && div_done) begin
      // Quotient at or above one in Q.F times 2^(31-F) saturates.
      ang <= sat_mag(div_quot | {64{div_ovf}}, vd_neg);
    end
    if (out_load) begin
      m_tdata <= {ang, lin, acc_heading, acc_y, acc_x};
    end
  end

  ddo_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .a    (mul_a),
    .d    (mul_d),
    .done (mul_done),
    .prod (mul_prod)
  );

  ddo_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .num  (div_num),
    .den  (eff_track),
    .done (div_done),
    .quot (div_quot),
    .ovf  (div_ovf)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .x0      (cor_x0),
    .heading (acc_heading),
    .done    (cor_done),
    .xo      (cor_x),
    .yo      (cor_y)
  );

endmodule

// ----- rtl/ddo_checker.sv -----
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks for the wheel odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Only one word is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again before the previous word finished");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (.*);

// ----- verif/odom_checker.sv -----
// ----------------------------------------------------------------------------
// odom_checker
// Watches the input, output and register ports of the odometry block. It
// predicts the pose and velocity word for every accepted input word and
// compares it field by field with the words the block delivers.
// ----------------------------------------------------------------------------
module odom_checker import ddo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int FB    = FRAC_BITS_DEF;

  typedef struct packed {
    logic [31:0] ang;
    logic [31:0] lin;
    logic [31:0] heading;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

  logic [31:0] dist_tick;
  logic [30:0] track;
  logic [31:0] last_left, last_right;
  logic [31:0] pos_x, pos_y, heading;
  pose_t       expected_poses[$];

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [31:0] d,
                                            input int s);
    logic [127:0] p;
    p = {64'd0, a} * {96'd0, d};
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] clamp_mag(input logic [63:0] m, input logic neg);
    if (neg)
      return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(m));
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [31:0] clamp_sum(input logic [31:0] acc, input longint v);
    longint s;
    s = longint'(signed'(acc)) + v;
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  // Advances the tracked pose by one input word and returns the result word.
  task automatic advance_pose(input logic kind, input logic [191:0] d, output pose_t r);
    logic [31:0] lc, rc, wrapped, hsh, rr, delta;
    logic [1:0]  k;
    logic [63:0] len, m, t, q, rem, lm, tv, am;
    longint dl, dr, sum, diff, x, y, z, xs, ys, tmp, vl, vr, vs, vd;
    r = '0;
    if (kind == KIND_OVERRIDE) begin
      pos_x = d[127:96];
      pos_y = d[159:128];
      heading = d[191:160];
    end else begin
      lc = d[31:0];
      rc = d[63:32];
      wrapped = lc - last_left;
      dl = longint'(signed'(wrapped));
      wrapped = rc - last_right;
      dr = longint'(signed'(wrapped));
      last_left = lc;
      last_right = rc;
      len = (track == 0) ? 64'd1 : {33'd0, track};
      sum = dl + dr;
      diff = dl - dr;

      // Mean travel, clamped, scaled by the inverse gain, then rotated.
      m = mul_shift(magnitude(sum), dist_tick, 33 - FB);
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      m = (m * 64'h9B74_EDA8) >> 32;
      x = (sum < 0) ? -longint'(m) : longint'(m);
      y = 0;
      hsh = heading + 32'h2000_0000;
      k = hsh[31:30];
      rr = heading - {k, 30'd0};
      z = longint'(signed'(rr));
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
        end
      end
      case (k)
        2'd1: begin tmp = x; x = -y; y = tmp; end
        2'd2: begin x = -x; y = -y; end
        2'd3: begin tmp = x; x = y; y = -tmp; end
        default: ;
      endcase
      pos_x = clamp_sum(pos_x, x);
      pos_y = clamp_sum(pos_y, y);

      t = mul_shift(magnitude(diff), dist_tick, 32 - FB);
      q = t / len;
      rem = t % len;
      rem = (rem << 32) / len;
      delta = 32'(q * 64'd683565276 + ((rem * 64'd683565276) >> 32));
      if (diff < 0) delta = -delta;
      heading = heading + delta;

      vl = longint'(signed'(d[79:64]));
      vr = longint'(signed'(d[95:80]));
      vs = vl + vr;
      vd = vl - vr;
      lm = mul_shift(magnitude(vs), dist_tick, 33 - FB);
      tv = mul_shift(magnitude(vd), dist_tick, 32 - FB);
      r.lin = clamp_mag(lm, vs < 0);
      q = tv / len;
      rem = tv % len;
      if (q >= (64'd1 << (31 - FB))) am = 64'hF_FFFF_FFFF;
      else am = (q << FB) + ((rem << FB) / len);
      r.ang = clamp_mag(am, vd < 0);
    end
    r.x = pos_x;
    r.y = pos_y;
    r.heading = heading;
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pose_t p, got;
    if (rst) begin
      dist_tick <= DPT_RESET;
      track <= TRACK_RESET;
      last_left = '0; last_right = '0;
      pos_x = '0; pos_y = '0; heading = '0;
      expected_poses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIST_PER_TICK) dist_tick <= cfg_data;
        else track <= cfg_data[30:0];
      end
      if (s_tvalid && s_tready) begin
        advance_pose(s_tuser, s_tdata, p);
        expected_poses.push_back(p);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_poses.size() == 0) begin
          $display("%0t unexpected word %h", $time, m_tdata);
          errors++;
        end else begin
          p = expected_poses.pop_front();
          check_field("pose_x", p.x, got.x);
          check_field("pose_y", p.y, got.y);
          check_field("pose_heading", p.heading, got.heading);
          check_field("lin_vel", p.lin, got.lin);
          check_field("ang_vel", p.ang, got.ang);
        end
      end
    end
    pending = expected_poses.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives encoder samples and pose overrides into the odometry block under
// several register settings, with random stalls on both streams and one
// long output hold-off; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_data = '0;
  int           errors, pending;
  bit           quiet = 0;
  bit           hold_req = 0;
  longint       cycles = 0;
  logic [31:0]  left_pos = '0, right_pos = '0;

  always #5 clk = ~clk;

  diff_drive_odometry DUT (.*);

  odom_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic kind, input logic [191:0] d);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic send_override(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] h);
    send_word(KIND_OVERRIDE, {h, y, x, $urandom(), $urandom(), $urandom()});
  endtask

  task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc,
                             input logic [15:0] lr, input logic [15:0] rr);
    left_pos = lc;
    right_pos = rc;
    send_word(KIND_SAMPLE, {$urandom(), $urandom(), $urandom(), rr, lr, rc, lc});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Mostly small count steps from the last position, sometimes wild jumps or pose overrides.
  task automatic random_word();
    logic [31:0] dl, dr;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      send_override($urandom(), $urandom(), $urandom());
    end else if (sel < 22) begin
      send_sample($urandom(), $urandom(), 16'($urandom()), 16'($urandom()));
    end else begin
      dl = $urandom_range(0, 1) ? 32'($urandom_range(0, 4000)) - 32'd2000
                                : 32'($urandom_range(0, 400000)) - 32'd200000;
      dr = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 4000)) - 32'd2000
                                     : dl + 32'($urandom_range(0, 200)) - 32'd100;
      send_sample(left_pos + dl, right_pos + dr, 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, quarter-turn boundaries, wrap, huge step, saturation.
    send_override(32'h7FFF_FFFF, 32'h8000_0000, 32'h1FFF_FFFF);
    send_sample(32'd1000, 32'd1000, 16'h7FFF, 16'h7FFF);
    send_override('0, '0, 32'h2000_0000);
    send_sample(32'd2000, 32'd1500, 16'h8000, 16'h8000);
    send_override('0, '0, 32'h6000_0000);
    send_sample(32'd500, 32'd2500, 16'h7FFF, 16'h8000);
    send_override('0, '0, 32'hE000_0000);
    send_sample(32'd900, 32'd900, 16'h8000, 16'h7FFF);
    send_override('0, '0, 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0);
    send_sample(32'h8000_0000, 32'h8000_0000, 16'h1, 16'hFFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 16'h0, 16'h0);
    send_sample(32'h7FFF_FFFE, 32'h8000_0001, 16'h0, 16'h0);
    send_override(32'h7FFF_0000, 32'h7FFF_0000, 32'h1000_0000);
    send_sample(32'h7FFF_FFFE, 32'h7FFF_FFFF, 16'h0, 16'h0);
    send_override(32'h8000_0000, 32'h8000_0000, 32'h9000_0000);
    send_sample(32'h8000_0001, 32'h8000_0001, 16'h0, 16'h0);
    send_override('0, '0, '0);
    drain();

    // Register extremes, a zero track width and an out-of-range upper bit.
    write_reg(REG_DIST_PER_TICK, 32'hFFFF_FFFF);
    write_reg(REG_TRACK_WIDTH, 32'h0);
    send_sample(left_pos + 32'h7FFF_FFFF, right_pos - 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    send_sample(left_pos + 32'd3, right_pos, 16'h8000, 16'h8000);
    for (int n = 0; n < 150; n++) random_word();
    drain();

    write_reg(REG_DIST_PER_TICK, 32'h0);
    write_reg(REG_TRACK_WIDTH, 32'hFFFF_FFFF);
    for (int n = 0; n < 100; n++) random_word();
    drain();

    write_reg(REG_DIST_PER_TICK, 32'd1);
    write_reg(REG_TRACK_WIDTH, 32'd1);
    for (int n = 0; n < 100; n++) random_word();
    drain();

    write_reg(REG_DIST_PER_TICK, $urandom());
    write_reg(REG_TRACK_WIDTH, $urandom());
    // The output is held off while overrides keep coming, so the block backs up.
    hold_req = 1;
    for (int n = 0; n < 20; n++) send_override($urandom(), $urandom(), $urandom());
    for (int n = 0; n < 180; n++) random_word();
    drain();

    write_reg(REG_DIST_PER_TICK, DPT_RESET);
    write_reg(REG_TRACK_WIDTH, 32'(TRACK_RESET));
    for (int n = 0; n < 230; n++) random_word();
    quiet = 1;
    for (int n = 0; n < 100; n++) random_word();
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
